/* hw/rtl/abrq_pkg.sv */
// ----------------------------------------------------------------------------
// abrq_pkg
// Shared constants, codes and types of the audio block ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package abrq_pkg;

    localparam int RING_BLOCKS       = 16;
    localparam int MAX_BLOCK_SAMPLES = 64;

    localparam int BLK_W  = $clog2(RING_BLOCKS);
    localparam int SLOT_W = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 16;
    localparam int SMP_W  = 32;
    localparam int ADDR_W = $clog2(RING_BLOCKS * MAX_BLOCK_SAMPLES);
    localparam int PROD_W = BLK_W + LEN_W;

    localparam logic [LEN_W-1:0] SPB_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] SPB_MAX   = LEN_W'(MAX_BLOCK_SAMPLES);

    localparam logic [2:0] REG_SPB = 3'd0;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_SILENT  = 2'd1,
        FUNC_POP     = 2'd2,
        FUNC_DISCARD = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_INVALID   = 3'd2,
        ST_SAMPLE    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_TOO_SMALL = 3'd5,
        ST_DISCARDED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SILENT = 2'd1,
        S_DONE   = 2'd2,
        S_POP    = 2'd3
    } fsm_t;

    function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b);
        next_blk = (b == BLK_W'(RING_BLOCKS - 1)) ? '0 : b + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BLK_W-1:0] b,
                                                    input logic [SLOT_W-1:0] o);
        slot_addr = ADDR_W'(b) * ADDR_W'(MAX_BLOCK_SAMPLES) + ADDR_W'(o);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/audio_block_ring_queue.sv */
// ----------------------------------------------------------------------------
// audio_block_ring_queue
// Ring of sample blocks with whole-packet admission and block pop.
// ----------------------------------------------------------------------------
// A push beat gives one result. A silent packet is accepted, then fills its
// blocks one after another in S_SILENT and reports from S_DONE. A pop streams
// one sample per cycle from the registered read port of the sample RAM while
// m_tready does not stall the result beat, and holds the input until the last
// sample of the block is sent. A result beat that waits on m_tready holds the
// item back. Silent blocks are tracked by a flag per block and read as zeros,
// so the RAM needs no clearing pass after reset.
`default_nettype none

module audio_block_ring_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // sample[31:0], packet_count[47:32], dest_capacity[63:48]
    input  wire logic [1:0]  s_tuser,  // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // out_sample[31:0], block_length[38:32], queue_empty[39]
    output logic [2:0]       m_tuser,  // status[2:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int BW = abrq_pkg::BLK_W;
    localparam int LW = abrq_pkg::LEN_W;
    localparam int CW = abrq_pkg::CNT_W;
    localparam int OW = abrq_pkg::SLOT_W;
    localparam int AW = abrq_pkg::ADDR_W;
    localparam int PW = abrq_pkg::PROD_W;
    localparam int RB = abrq_pkg::RING_BLOCKS;

    abrq_pkg::fsm_t state_reg, state_next;

    logic [LW-1:0] spb_reg, spb_next;
    logic [LW-1:0] fill_reg [RB];
    logic [LW-1:0] fill_next [RB];
    logic [RB-1:0] silent_reg, silent_next;
    logic [BW-1:0] commit_reg, commit_next;
    logic [BW-1:0] tail_reg, tail_next;
    logic [BW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] left_reg, left_next;
    logic          taken_reg, taken_next;
    logic [LW-1:0] offset_reg, offset_next;
    logic [CW-1:0] sil_left_reg, sil_left_next;
    logic [BW-1:0] sil_blk_reg, sil_blk_next;
    logic [OW-1:0] idx_reg, idx_next;
    logic [LW-1:0] plen_reg, plen_next;

    logic                 m_valid_reg, m_valid_next;
    abrq_pkg::status_t    m_status_reg, m_status_next;
    logic [31:0]          m_sample_reg, m_sample_next;
    logic [LW-1:0]        m_len_reg, m_len_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_empty_reg, m_empty_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_q;

    abrq_pkg::func_t func;
    logic [31:0]   in_sample;
    logic [CW-1:0] in_count;
    logic [CW-1:0] in_cap;
    logic          slot_free, acc;
    logic [LW-1:0] spb_eff;
    logic [BW-1:0] used, free_cnt;
    logic [PW-1:0] room;
    logic          fits;
    logic [LW-1:0] head_len;
    logic          pop_go, silent_go;
    logic [LW-1:0] sil_take;
    logic          sil_end;
    logic          pop_last;
    logic          cfg_wr;

    assign func      = abrq_pkg::func_t'(s_tuser);
    assign in_sample = s_tdata[31:0];
    assign in_count  = s_tdata[47:32];
    assign in_cap    = s_tdata[63:48];

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == abrq_pkg::S_IDLE) && slot_free;
    assign acc       = s_tvalid && s_tready;

    assign spb_eff = (spb_reg == '0) ? LW'(1) :
                     (spb_reg > abrq_pkg::SPB_MAX) ? abrq_pkg::SPB_MAX : spb_reg;

    assign used     = (commit_reg >= tail_reg) ? commit_reg - tail_reg
                                               : BW'(32'(commit_reg) + RB - 32'(tail_reg));
    assign free_cnt = BW'(RB - 1) - used;
    assign room     = PW'(free_cnt) * PW'(spb_eff);
    assign fits     = {1'b0, in_count} <= 17'(room);

    assign head_len  = fill_reg[tail_reg];
    assign pop_go    = (func == abrq_pkg::FUNC_POP) && (tail_reg != commit_reg)
                       && ({9'b0, head_len} <= in_cap) && (head_len != '0);
    assign silent_go = (func == abrq_pkg::FUNC_SILENT) && (left_reg == '0)
                       && (in_count != '0) && fits;

    assign sil_take = (sil_left_reg < CW'(spb_eff)) ? sil_left_reg[LW-1:0] : spb_eff;
    assign sil_end  = (sil_left_reg <= CW'(spb_eff));
    assign pop_last = (LW'(idx_reg) + 1'b1) == plen_reg;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {25'b0, spb_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_empty_reg, m_len_reg, m_sample_reg};
    assign m_tlast  = m_last_reg;

    abrq_ram #(
        .WIDTH(32),
        .DEPTH(RB * abrq_pkg::MAX_BLOCK_SAMPLES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_sample),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abrq_pkg::S_IDLE:
            begin
                if (acc && pop_go)
                begin
                    state_next = abrq_pkg::S_POP;
                end
                else if (acc && silent_go)
                begin
                    state_next = abrq_pkg::S_SILENT;
                end
            end
            abrq_pkg::S_SILENT:
            begin
                if (sil_end)
                begin
                    state_next = abrq_pkg::S_DONE;
                end
            end
            abrq_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = abrq_pkg::S_IDLE;
                end
            end
            abrq_pkg::S_POP:
            begin
                if (slot_free && pop_last)
                begin
                    state_next = abrq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = abrq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [LW-1:0] off1;
        logic [CW-1:0] left1;
        logic [BW-1:0] cur;
        logic          go;
        spb_next      = spb_reg;
        fill_next     = fill_reg;
        silent_next   = silent_reg;
        commit_next   = commit_reg;
        tail_next     = tail_reg;
        cursor_next   = cursor_reg;
        left_next     = left_reg;
        taken_next    = taken_reg;
        offset_next   = offset_reg;
        sil_left_next = sil_left_reg;
        sil_blk_next  = sil_blk_reg;
        idx_next      = idx_reg;
        plen_next     = plen_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_sample_next = m_sample_reg;
        m_len_next    = m_len_reg;
        m_last_next   = m_last_reg;
        m_empty_next  = m_empty_reg;
        ram_we        = 1'b0;
        ram_waddr     = abrq_pkg::slot_addr(cursor_reg, offset_reg[OW-1:0]);
        ram_re        = 1'b0;
        ram_raddr     = abrq_pkg::slot_addr(tail_reg, '0);
        off1          = '0;
        left1         = '0;
        cur           = cursor_reg;
        go            = 1'b0;

        if (cfg_wr && (paddr[2] == abrq_pkg::REG_SPB[0]) && (left_reg == '0))
        begin
            spb_next = pwdata[LW-1:0];
        end

        unique case (state_reg)
            abrq_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    m_valid_next  = 1'b1;
                    m_sample_next = '0;
                    m_len_next    = '0;
                    m_last_next   = 1'b1;
                    unique case (func)
                        abrq_pkg::FUNC_PUSH:
                        begin
                            if (left_reg == '0)
                            begin
                                if (in_count == '0)
                                begin
                                    m_status_next = abrq_pkg::ST_INVALID;
                                end
                                else if (!fits)
                                begin
                                    left_next     = in_count - 1'b1;
                                    offset_next   = '0;
                                    cursor_next   = commit_reg;
                                    taken_next    = 1'b0;
                                    m_status_next = abrq_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    go    = 1'b1;
                                    cur   = commit_reg;
                                    off1  = LW'(1);
                                    left1 = in_count - 1'b1;
                                    ram_waddr = abrq_pkg::slot_addr(commit_reg, '0);
                                end
                            end
                            else if (!taken_reg)
                            begin
                                left_next     = left_reg - 1'b1;
                                m_status_next = abrq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                go    = 1'b1;
                                off1  = offset_reg + 1'b1;
                                left1 = left_reg - 1'b1;
                            end
                            if (go)
                            begin
                                ram_we        = 1'b1;
                                m_status_next = abrq_pkg::ST_ACCEPTED;
                                left_next     = left1;
                                offset_next   = off1;
                                cursor_next   = cur;
                                taken_next    = 1'b1;
                                if ((off1 >= spb_eff) || (left1 == '0))
                                begin
                                    fill_next[cur]   = off1;
                                    silent_next[cur] = 1'b0;
                                    cursor_next      = abrq_pkg::next_blk(cur);
                                    offset_next      = '0;
                                end
                                if (left1 == '0)
                                begin
                                    commit_next = abrq_pkg::next_blk(cur);
                                    taken_next  = 1'b0;
                                end
                            end
                        end
                        abrq_pkg::FUNC_SILENT:
                        begin
                            if ((left_reg != '0) || (in_count == '0))
                            begin
                                m_status_next = abrq_pkg::ST_INVALID;
                            end
                            else if (!fits)
                            begin
                                m_status_next = abrq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                m_valid_next  = m_valid_reg && !m_tready;
                                sil_left_next = in_count;
                                sil_blk_next  = commit_reg;
                            end
                        end
                        abrq_pkg::FUNC_POP:
                        begin
                            if (tail_reg == commit_reg)
                            begin
                                m_status_next = abrq_pkg::ST_EMPTY;
                            end
                            else if ({9'b0, head_len} > in_cap)
                            begin
                                m_status_next = abrq_pkg::ST_TOO_SMALL;
                            end
                            else if (head_len == '0)
                            begin
                                m_status_next = abrq_pkg::ST_EMPTY;
                                tail_next     = abrq_pkg::next_blk(tail_reg);
                            end
                            else
                            begin
                                m_valid_next = m_valid_reg && !m_tready;
                                ram_re       = 1'b1;
                                idx_next     = '0;
                                plen_next    = head_len;
                            end
                        end
                        abrq_pkg::FUNC_DISCARD:
                        begin
                            m_status_next = abrq_pkg::ST_DISCARDED;
                            for (int i = 0; i < RB; i++)
                            begin
                                fill_next[i] = '0;
                            end
                            silent_next = '0;
                            commit_next = '0;
                            tail_next   = '0;
                            cursor_next = '0;
                            left_next   = '0;
                            taken_next  = 1'b0;
                            offset_next = '0;
                        end
                        default:
                        begin
                            m_status_next = abrq_pkg::ST_INVALID;
                        end
                    endcase
                    m_empty_next = (tail_next == commit_next);
                end
            end
            abrq_pkg::S_SILENT:
            begin
                fill_next[sil_blk_reg]   = sil_take;
                silent_next[sil_blk_reg] = 1'b1;
                sil_left_next            = sil_left_reg - CW'(sil_take);
                sil_blk_next             = abrq_pkg::next_blk(sil_blk_reg);
                if (sil_end)
                begin
                    commit_next = abrq_pkg::next_blk(sil_blk_reg);
                    cursor_next = abrq_pkg::next_blk(sil_blk_reg);
                end
            end
            abrq_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = abrq_pkg::ST_ACCEPTED;
                    m_sample_next = '0;
                    m_len_next    = '0;
                    m_last_next   = 1'b1;
                    m_empty_next  = (tail_reg == commit_reg);
                end
            end
            abrq_pkg::S_POP:
            begin
                if (slot_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = abrq_pkg::ST_SAMPLE;
                    m_sample_next = silent_reg[tail_reg] ? '0 : ram_q;
                    m_len_next    = plen_reg;
                    m_last_next   = pop_last;
                    m_empty_next  = (abrq_pkg::next_blk(tail_reg) == commit_reg);
                    if (pop_last)
                    begin
                        fill_next[tail_reg]   = '0;
                        silent_next[tail_reg] = 1'b0;
                        tail_next             = abrq_pkg::next_blk(tail_reg);
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = abrq_pkg::slot_addr(tail_reg, idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= abrq_pkg::S_IDLE;
            spb_reg     <= abrq_pkg::SPB_RESET;
            for (int i = 0; i < RB; i++)
            begin
                fill_reg[i] <= '0;
            end
            silent_reg  <= '0;
            commit_reg  <= '0;
            tail_reg    <= '0;
            cursor_reg  <= '0;
            left_reg    <= '0;
            taken_reg   <= 1'b0;
            offset_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            spb_reg     <= spb_next;
            fill_reg    <= fill_next;
            silent_reg  <= silent_next;
            commit_reg  <= commit_next;
            tail_reg    <= tail_next;
            cursor_reg  <= cursor_next;
            left_reg    <= left_next;
            taken_reg   <= taken_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sil_left_reg <= sil_left_next;
        sil_blk_reg  <= sil_blk_next;
        idx_reg      <= idx_next;
        plen_reg     <= plen_next;
        m_status_reg <= m_status_next;
        m_sample_reg <= m_sample_next;
        m_len_reg    <= m_len_next;
        m_last_reg   <= m_last_next;
        m_empty_reg  <= m_empty_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/abrq_ram.sv */
// ----------------------------------------------------------------------------
// abrq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module abrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/abrq_checker.sv */
// ----------------------------------------------------------------------------
// abrq_assertions
// Port-level checks of the audio block ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abrq_assertions (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != abrq_pkg::ST_SAMPLE) |-> m_tlast)
        else $error("single-result beat without last");

    a_sample_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == abrq_pkg::ST_SAMPLE) |-> (m_tdata[38:32] != '0))
        else $error("popped sample with zero block length");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == abrq_pkg::ST_SAMPLE) && !m_tlast |-> !s_tready)
        else $error("input taken during block pop");

endmodule

bind audio_block_ring_queue abrq_assertions u_abrq_assertions (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire
